>>> rtl/core/lpsc_pkg.sv
// Shared types and constants for the LRU page slot cache.
package lpsc_pkg;

  // Commands carried on the input channel
  typedef enum logic [1:0] {
    CMD_TOUCH   = 2'd0,
    CMD_REQUEST = 2'd1,
    CMD_LOAD    = 2'd2,
    CMD_CLEAR   = 2'd3
  } lpsc_cmd_t;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_FIND = 2'd1,
    ST_GATH = 2'd2,
    ST_UPD  = 2'd3
  } lpsc_state_t;

  // Update broadcast to every cell
  typedef enum logic [2:0] {
    OP_NONE  = 3'd0,
    OP_TOUCH = 3'd1,
    OP_FILL  = 3'd2,
    OP_EVICT = 3'd3,
    OP_CLEAR = 3'd4
  } lpsc_op_t;

  typedef struct packed {
    logic     find;
    lpsc_op_t op;
  } lpsc_ctl_t;

  localparam int unsigned COORD_W = 3;
  localparam int unsigned SIDE_W  = 4;
  localparam int unsigned GRP     = 8;
  localparam logic [SIDE_W-1:0] RESET_SIDE = 4'd8;
  localparam logic [SIDE_W-1:0] MAX_SIDE   = 4'd8;

endpackage

>>> rtl/core/lpsc_cell.sv
// One cache cell: tag, valid, recency rank and atlas position of one slot.
module lpsc_cell import lpsc_pkg::*; #(
  parameter int unsigned KW = 16,
  parameter int unsigned RW = 6
) (
  input  logic               clk,
  input  logic               rst_n,
  input  lpsc_ctl_t          ctl_i,
  input  logic [KW-1:0]      key_i,
  input  logic [RW-1:0]      thresh_i,
  input  logic [RW-1:0]      vic_rank_i,
  input  logic [COORD_W-1:0] fill_x_i,
  input  logic [COORD_W-1:0] fill_y_i,
  input  logic               prev_valid_i,
  output logic               valid_o,
  output logic               hit_o,
  output logic               vic_o,
  output logic [RW-1:0]      rank_o,
  output logic [KW-1:0]      tag_o,
  output logic [COORD_W-1:0] x_o,
  output logic [COORD_W-1:0] y_o
);

  logic               valid_r, valid_nxt;
  logic               hit_r, hit_nxt;
  logic               vic_r, vic_nxt;
  logic [RW-1:0]      rank_r, rank_nxt;
  logic [KW-1:0]      tag_r, tag_nxt;
  logic [COORD_W-1:0] x_r, x_nxt;
  logic [COORD_W-1:0] y_r, y_nxt;
  logic               older;

  assign older = valid_r && (rank_r < thresh_i);

  always_comb begin
    valid_nxt = valid_r;
    hit_nxt   = hit_r;
    vic_nxt   = vic_r;
    rank_nxt  = rank_r;
    tag_nxt   = tag_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    if (ctl_i.find) begin
      hit_nxt = valid_r && (tag_r == key_i);
      vic_nxt = valid_r && (rank_r == vic_rank_i);
    end
    case (ctl_i.op)
      OP_TOUCH: begin
        if (hit_r) begin
          rank_nxt = '0;
        end else if (older) begin
          rank_nxt = rank_r + RW'(1);
        end
      end
      OP_FILL: begin
        // the first empty cell of the row, behind a filled neighbor, takes the broadcast key and fill position
        if (!valid_r && prev_valid_i) begin
          valid_nxt = 1'b1;
          tag_nxt   = key_i;
          x_nxt     = fill_x_i;
          y_nxt     = fill_y_i;
          rank_nxt  = '0;
        end else if (valid_r) begin
          rank_nxt = rank_r + RW'(1);
        end
      end
      OP_EVICT: begin
        if (vic_r) begin
          tag_nxt  = key_i;
          rank_nxt = '0;
        end else if (older) begin
          rank_nxt = rank_r + RW'(1);
        end
      end
      OP_CLEAR: begin
        valid_nxt = 1'b0;
        rank_nxt  = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      hit_r   <= 1'b0;
      vic_r   <= 1'b0;
      rank_r  <= '0;
    end else begin
      valid_r <= valid_nxt;
      hit_r   <= hit_nxt;
      vic_r   <= vic_nxt;
      rank_r  <= rank_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tag_r <= tag_nxt;
    x_r   <= x_nxt;
    y_r   <= y_nxt;
  end

  assign valid_o = valid_r;
  assign hit_o   = hit_r;
  assign vic_o   = vic_r;
  assign rank_o  = rank_r;
  assign tag_o   = tag_r;
  assign x_o     = x_r;
  assign y_o     = y_r;

endmodule

>>> rtl/core/lpsc_gather.sv
// Registered one-hot select over a group of cells: hit fields and victim fields.
module lpsc_gather import lpsc_pkg::*; #(
  parameter int unsigned N  = 8,
  parameter int unsigned KW = 16,
  parameter int unsigned RW = 6
) (
  input  logic                      clk,
  input  logic [N-1:0]              hit_i,
  input  logic [N-1:0]              vic_i,
  input  logic [N-1:0][RW-1:0]      rank_i,
  input  logic [N-1:0][KW-1:0]      tag_i,
  input  logic [N-1:0][COORD_W-1:0] x_i,
  input  logic [N-1:0][COORD_W-1:0] y_i,
  output logic                      hit_o,
  output logic [RW-1:0]             hit_rank_o,
  output logic [COORD_W-1:0]        hit_x_o,
  output logic [COORD_W-1:0]        hit_y_o,
  output logic [KW-1:0]             vic_tag_o,
  output logic [COORD_W-1:0]        vic_x_o,
  output logic [COORD_W-1:0]        vic_y_o
);

  logic               hit_r, hit_nxt;
  logic [RW-1:0]      hit_rank_r, hit_rank_nxt;
  logic [COORD_W-1:0] hit_x_r, hit_x_nxt;
  logic [COORD_W-1:0] hit_y_r, hit_y_nxt;
  logic [KW-1:0]      vic_tag_r, vic_tag_nxt;
  logic [COORD_W-1:0] vic_x_r, vic_x_nxt;
  logic [COORD_W-1:0] vic_y_r, vic_y_nxt;

  // at most one hit and one victim per group, so an and-or select suffices
  always_comb begin
    hit_nxt      = 1'b0;
    hit_rank_nxt = '0;
    hit_x_nxt    = '0;
    hit_y_nxt    = '0;
    vic_tag_nxt  = '0;
    vic_x_nxt    = '0;
    vic_y_nxt    = '0;
    for (int i = 0; i < N; i++) begin
      hit_nxt      = hit_nxt | hit_i[i];
      hit_rank_nxt = hit_rank_nxt | (rank_i[i] & {RW{hit_i[i]}});
      hit_x_nxt    = hit_x_nxt | (x_i[i] & {COORD_W{hit_i[i]}});
      hit_y_nxt    = hit_y_nxt | (y_i[i] & {COORD_W{hit_i[i]}});
      vic_tag_nxt  = vic_tag_nxt | (tag_i[i] & {KW{vic_i[i]}});
      vic_x_nxt    = vic_x_nxt | (x_i[i] & {COORD_W{vic_i[i]}});
      vic_y_nxt    = vic_y_nxt | (y_i[i] & {COORD_W{vic_i[i]}});
    end
  end

  always_ff @(posedge clk) begin
    hit_r      <= hit_nxt;
    hit_rank_r <= hit_rank_nxt;
    hit_x_r    <= hit_x_nxt;
    hit_y_r    <= hit_y_nxt;
    vic_tag_r  <= vic_tag_nxt;
    vic_x_r    <= vic_x_nxt;
    vic_y_r    <= vic_y_nxt;
  end

  assign hit_o      = hit_r;
  assign hit_rank_o = hit_rank_r;
  assign hit_x_o    = hit_x_r;
  assign hit_y_o    = hit_y_r;
  assign vic_tag_o  = vic_tag_r;
  assign vic_x_o    = vic_x_r;
  assign vic_y_o    = vic_y_r;

endmodule

>>> rtl/core/lru_page_slot_cache_unit.sv
// Top level of the LRU page slot cache: sequencer, cell row, gather tree and result register.
//
// Each input word carries a command (touch, request, load complete, clear) and a page key;
// each command yields exactly one result word. A load complete of a non-resident key places it in the next
// free atlas slot in row order, or evicts the least recent key once the atlas is full.
// Cells sit in a row; each holds one slot's tag, rank and position, and the first empty
// cell behind a filled neighbor takes the next load.
// Sequence: a word is accepted in idle, the cells compare it in the next cycle, the group
// selects register in the one after, and the update plus result register follow; a new
// word is taken only once the update of the previous word is done.
// in_stall is high while a word is in flight. If the result register is still held by
// out_stall when the update is due, the update waits until it drains.
// cfg_wr_en writes the atlas side (0 reads as 1, above 8 as 8, then lowered until its
// square fits in MAX_SLOTS) and empties the cache; write it only while idle.
// Reset empties the cache, sets the side to 8 and leaves the result channel empty.
module lru_page_slot_cache_unit import lpsc_pkg::*; #(
  parameter int unsigned MAX_SLOTS = 64,
  parameter int unsigned KEY_BITS  = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [SIDE_W-1:0]   cfg_wr_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          in_cmd,
  input  logic [KEY_BITS-1:0] in_page_key,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_was_resident,
  output logic                out_load_issue,
  output logic [COORD_W-1:0]  out_slot_x,
  output logic [COORD_W-1:0]  out_slot_y,
  output logic                out_evicted,
  output logic [KEY_BITS-1:0] out_evicted_key
);

  localparam int unsigned RW    = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_SLOTS + 1);
  localparam int unsigned NGRP  = (MAX_SLOTS + GRP - 1) / GRP;
  localparam int unsigned NPAD  = NGRP * GRP;

  function automatic logic [SIDE_W-1:0] eff_side(input logic [SIDE_W-1:0] v);
    logic [SIDE_W-1:0] c;
    logic [SIDE_W-1:0] best;
    c    = v;
    best = SIDE_W'(1);
    if (c == '0) c = SIDE_W'(1);
    if (c > MAX_SIDE) c = MAX_SIDE;
    for (int s = 1; s <= 8; s++) begin
      if ((SIDE_W'(s) <= c) && (s * s <= MAX_SLOTS)) best = SIDE_W'(s);
    end
    return best;
  endfunction

  lpsc_state_t state_r, state_nxt;

  logic [SIDE_W-1:0]   side_r, side_nxt;
  logic [CNT_W-1:0]    cap_r, cap_nxt;
  logic [CNT_W-1:0]    fill_r, fill_nxt;
  logic [COORD_W-1:0]  fill_x_r, fill_x_nxt;
  logic [COORD_W-1:0]  fill_y_r, fill_y_nxt;
  lpsc_cmd_t           cmd_r, cmd_nxt;
  logic [KEY_BITS-1:0] key_r, key_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic                was_res_r, was_res_nxt;
  logic                load_iss_r, load_iss_nxt;
  logic [COORD_W-1:0]  sx_r, sx_nxt;
  logic [COORD_W-1:0]  sy_r, sy_nxt;
  logic                ev_r, ev_nxt;
  logic [KEY_BITS-1:0] evkey_r, evkey_nxt;

  logic                in_take;
  logic                upd_go;
  logic                room;
  logic [CNT_W-1:0]    fill_dec;
  logic [RW-1:0]       vic_rank;
  logic [RW-1:0]       thresh;
  logic [6:0]          side_sq;
  logic [SIDE_W-1:0]   side_new;
  logic [SIDE_W-1:0]   x_inc;
  lpsc_ctl_t           ctl;

  logic [NPAD-1:0]                    valid_pad;
  logic [NPAD-1:0]                    hit_pad;
  logic [NPAD-1:0]                    vic_pad;
  logic [NPAD-1:0][RW-1:0]            rank_pad;
  logic [NPAD-1:0][KEY_BITS-1:0]      tag_pad;
  logic [NPAD-1:0][COORD_W-1:0]       x_pad;
  logic [NPAD-1:0][COORD_W-1:0]       y_pad;

  logic [NGRP-1:0]                    g_hit;
  logic [NGRP-1:0][RW-1:0]            g_hit_rank;
  logic [NGRP-1:0][COORD_W-1:0]       g_hit_x;
  logic [NGRP-1:0][COORD_W-1:0]       g_hit_y;
  logic [NGRP-1:0][KEY_BITS-1:0]      g_vic_tag;
  logic [NGRP-1:0][COORD_W-1:0]       g_vic_x;
  logic [NGRP-1:0][COORD_W-1:0]       g_vic_y;

  logic                hit;
  logic [RW-1:0]       hit_rank;
  logic [COORD_W-1:0]  hit_x;
  logic [COORD_W-1:0]  hit_y;
  logic [KEY_BITS-1:0] vic_tag;
  logic [COORD_W-1:0]  vic_x;
  logic [COORD_W-1:0]  vic_y;

  // ---------------------------------------------------------------- cell row
  for (genvar i = 0; i < NPAD; i++) begin : g_cell
    if (i < MAX_SLOTS) begin : g_real
      logic prev_valid;
      if (i == 0) begin : g_head
        assign prev_valid = 1'b1;
      end else begin : g_link
        assign prev_valid = valid_pad[i-1];
      end
      lpsc_cell #(.KW(KEY_BITS), .RW(RW)) u_cell (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl_i       (ctl),
        .key_i       (key_r),
        .thresh_i    (thresh),
        .vic_rank_i  (vic_rank),
        .fill_x_i    (fill_x_r),
        .fill_y_i    (fill_y_r),
        .prev_valid_i(prev_valid),
        .valid_o     (valid_pad[i]),
        .hit_o       (hit_pad[i]),
        .vic_o       (vic_pad[i]),
        .rank_o      (rank_pad[i]),
        .tag_o       (tag_pad[i]),
        .x_o         (x_pad[i]),
        .y_o         (y_pad[i])
      );
    end else begin : g_pad
      assign valid_pad[i] = 1'b0;
      assign hit_pad[i]   = 1'b0;
      assign vic_pad[i]   = 1'b0;
      assign rank_pad[i]  = '0;
      assign tag_pad[i]   = '0;
      assign x_pad[i]     = '0;
      assign y_pad[i]     = '0;
    end
  end

  // ---------------------------------------------------------------- gather tree
  for (genvar g = 0; g < NGRP; g++) begin : g_grp
    lpsc_gather #(.N(GRP), .KW(KEY_BITS), .RW(RW)) u_gather (
      .clk       (clk),
      .hit_i     (hit_pad[g*GRP +: GRP]),
      .vic_i     (vic_pad[g*GRP +: GRP]),
      .rank_i    (rank_pad[g*GRP +: GRP]),
      .tag_i     (tag_pad[g*GRP +: GRP]),
      .x_i       (x_pad[g*GRP +: GRP]),
      .y_i       (y_pad[g*GRP +: GRP]),
      .hit_o     (g_hit[g]),
      .hit_rank_o(g_hit_rank[g]),
      .hit_x_o   (g_hit_x[g]),
      .hit_y_o   (g_hit_y[g]),
      .vic_tag_o (g_vic_tag[g]),
      .vic_x_o   (g_vic_x[g]),
      .vic_y_o   (g_vic_y[g])
    );
  end

  // groups are already masked, so a plain or merges them
  always_comb begin
    hit      = 1'b0;
    hit_rank = '0;
    hit_x    = '0;
    hit_y    = '0;
    vic_tag  = '0;
    vic_x    = '0;
    vic_y    = '0;
    for (int g = 0; g < NGRP; g++) begin
      hit      = hit | g_hit[g];
      hit_rank = hit_rank | g_hit_rank[g];
      hit_x    = hit_x | g_hit_x[g];
      hit_y    = hit_y | g_hit_y[g];
      vic_tag  = vic_tag | g_vic_tag[g];
      vic_x    = vic_x | g_vic_x[g];
      vic_y    = vic_y | g_vic_y[g];
    end
  end

  // ---------------------------------------------------------------- control
  assign room     = (fill_r < cap_r);
  assign fill_dec = fill_r - CNT_W'(1);
  assign vic_rank = fill_dec[RW-1:0];
  assign upd_go   = (state_r == ST_UPD) && (!out_valid_r || !out_stall);
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_FIND;
      ST_FIND: state_nxt = ST_GATH;
      ST_GATH: state_nxt = ST_UPD;
      ST_UPD:  if (!out_valid_r || !out_stall) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = (state_r != ST_IDLE);
    ctl.find = (state_r == ST_FIND);
    ctl.op   = OP_NONE;
    thresh   = hit ? hit_rank : vic_rank;
    if (upd_go) begin
      case (cmd_r)
        CMD_TOUCH: if (hit) ctl.op = OP_TOUCH;
        CMD_LOAD: begin
          if (hit) begin
            ctl.op = OP_TOUCH;
          end else if (room) begin
            ctl.op = OP_FILL;
          end else begin
            ctl.op = OP_EVICT;
          end
        end
        CMD_CLEAR: ctl.op = OP_CLEAR;
        default: ctl.op = OP_NONE;
      endcase
    end
    if (cfg_wr_en) ctl.op = OP_CLEAR;
  end

  // ---------------------------------------------------------------- datapath
  assign side_new = eff_side(cfg_wr_data);
  assign side_sq  = {3'b000, side_new} * {3'b000, side_new};
  assign x_inc    = {1'b0, fill_x_r} + SIDE_W'(1);

  always_comb begin
    side_nxt   = side_r;
    cap_nxt    = cap_r;
    fill_nxt   = fill_r;
    fill_x_nxt = fill_x_r;
    fill_y_nxt = fill_y_r;
    cmd_nxt    = cmd_r;
    key_nxt    = key_r;
    if (in_take) begin
      cmd_nxt = lpsc_cmd_t'(in_cmd);
      key_nxt = in_page_key;
    end
    case (ctl.op)
      OP_FILL: begin
        fill_nxt = fill_r + CNT_W'(1);
        if (x_inc == side_r) begin
          fill_x_nxt = '0;
          fill_y_nxt = fill_y_r + COORD_W'(1);
        end else begin
          fill_x_nxt = x_inc[COORD_W-1:0];
        end
      end
      OP_CLEAR: begin
        fill_nxt   = '0;
        fill_x_nxt = '0;
        fill_y_nxt = '0;
      end
      default: begin
      end
    endcase
    if (cfg_wr_en) begin
      side_nxt = side_new;
      cap_nxt  = CNT_W'(side_sq);
    end
  end

  // ---------------------------------------------------------------- result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    was_res_nxt   = was_res_r;
    load_iss_nxt  = load_iss_r;
    sx_nxt        = sx_r;
    sy_nxt        = sy_r;
    ev_nxt        = ev_r;
    evkey_nxt     = evkey_r;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    if (upd_go) begin
      out_valid_nxt = 1'b1;
      was_res_nxt   = hit;
      load_iss_nxt  = (cmd_r == CMD_REQUEST) && !hit;
      sx_nxt        = '0;
      sy_nxt        = '0;
      ev_nxt        = 1'b0;
      evkey_nxt     = '0;
      if (cmd_r == CMD_LOAD) begin
        if (hit) begin
          sx_nxt = hit_x;
          sy_nxt = hit_y;
        end else if (room) begin
          sx_nxt = fill_x_r;
          sy_nxt = fill_y_r;
        end else begin
          sx_nxt    = vic_x;
          sy_nxt    = vic_y;
          ev_nxt    = 1'b1;
          evkey_nxt = vic_tag;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      side_r      <= eff_side(RESET_SIDE);
      cap_r       <= CNT_W'({3'b000, eff_side(RESET_SIDE)} * {3'b000, eff_side(RESET_SIDE)});
      fill_r      <= '0;
      fill_x_r    <= '0;
      fill_y_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      side_r      <= side_nxt;
      cap_r       <= cap_nxt;
      fill_r      <= fill_nxt;
      fill_x_r    <= fill_x_nxt;
      fill_y_r    <= fill_y_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r    <= cmd_nxt;
    key_r    <= key_nxt;
    was_res_r <= was_res_nxt;
    load_iss_r <= load_iss_nxt;
    sx_r     <= sx_nxt;
    sy_r     <= sy_nxt;
    ev_r     <= ev_nxt;
    evkey_r  <= evkey_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_was_resident = was_res_r;
  assign out_load_issue   = load_iss_r;
  assign out_slot_x       = sx_r;
  assign out_slot_y       = sy_r;
  assign out_evicted      = ev_r;
  assign out_evicted_key  = evkey_r;

endmodule

>>> sim/testbench.sv
// Self-checking testbench for lru_page_slot_cache_unit with a built-in LRU slot predictor.
module testbench import lpsc_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS = 64;

  typedef struct {
    lpsc_cmd_t   cmd;
    logic [15:0] key;
  } page_word_t;

  typedef struct packed {
    logic        was_resident;
    logic        load_issue;
    logic [2:0]  slot_x;
    logic [2:0]  slot_y;
    logic        evicted;
    logic [15:0] evicted_key;
  } slot_reply_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [3:0]  cfg_wr_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_cmd = '0;
  logic [15:0] in_page_key = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_was_resident;
  logic        out_load_issue;
  logic [2:0]  out_slot_x;
  logic [2:0]  out_slot_y;
  logic        out_evicted;
  logic [15:0] out_evicted_key;

  logic in_took = 1'b0;
  logic out_took = 1'b0;
  int   in_gap = 0;
  int   out_hold = 0;
  int   max_wait = 15;

  page_word_t  pending_words[$];
  page_word_t  next_word;
  slot_reply_t expected_replies[$];
  slot_reply_t want_reply;

  // predictor state
  logic [15:0] page_tag[SLOTS];
  bit          page_live[SLOTS];
  int          page_age[SLOTS];
  int          pages_used;
  int          geom_side = 8;

  int mismatches = 0;
  int n_results = 0;
  int n_hits = 0;
  int n_loads = 0;
  int n_evictions = 0;
  int n_sides = 1;

  lru_page_slot_cache_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_cmd           (in_cmd),
    .in_page_key      (in_page_key),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_was_resident (out_was_resident),
    .out_load_issue   (out_load_issue),
    .out_slot_x       (out_slot_x),
    .out_slot_y       (out_slot_y),
    .out_evicted      (out_evicted),
    .out_evicted_key  (out_evicted_key)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic void drop_all();
    for (int i = 0; i < SLOTS; i++) begin
      page_live[i] = 1'b0;
      page_age[i]  = 0;
      page_tag[i]  = '0;
    end
    pages_used = 0;
  endfunction

  // Age every live slot that was more recent than this one, then make it newest.
  function automatic void make_newest(int slot, bit fresh);
    int old_age;
    old_age = fresh ? 2 * SLOTS : page_age[slot];
    for (int i = 0; i < SLOTS; i++)
      if (i != slot && page_live[i] && page_age[i] < old_age) page_age[i]++;
    page_age[slot] = 0;
  endfunction

  function automatic slot_reply_t apply_command(lpsc_cmd_t cmd, logic [15:0] key);
    slot_reply_t r;
    bit          hit;
    int          at;
    r   = '0;
    hit = 1'b0;
    at  = 0;
    for (int i = 0; i < SLOTS; i++)
      if (!hit && page_live[i] && page_tag[i] == key) begin
        hit = 1'b1;
        at  = i;
      end
    r.was_resident = hit;
    case (cmd)
      CMD_TOUCH: begin
        if (hit) make_newest(at, 1'b0);
      end
      CMD_REQUEST: begin
        r.load_issue = !hit;
      end
      CMD_LOAD: begin
        if (hit) begin
          make_newest(at, 1'b0);
        end else if (pages_used < geom_side * geom_side) begin
          at = pages_used;
          page_tag[at]  = key;
          page_live[at] = 1'b1;
          make_newest(at, 1'b1);
          pages_used++;
        end else begin
          // full atlas: take over the oldest live slot
          at = -1;
          for (int i = 0; i < SLOTS; i++)
            if (page_live[i] && (at < 0 || page_age[i] > page_age[at])) at = i;
          r.evicted     = 1'b1;
          r.evicted_key = page_tag[at];
          page_tag[at]  = key;
          make_newest(at, 1'b0);
        end
        r.slot_x = 3'(at % geom_side);
        r.slot_y = 3'(at / geom_side);
      end
      CMD_CLEAR: begin
        drop_all();
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatches++;
    $display("%0t ns: %s: got %0h, expected %0h", $time, what, got, want);
  endtask

  function automatic void send(lpsc_cmd_t c, logic [15:0] k);
    page_word_t w;
    w.cmd = c;
    w.key = k;
    pending_words.push_back(w);
  endfunction

  // Sender: hold a stalled word, otherwise idle for the drawn gap or present the next word.
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_took)) begin
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (pending_words.size() > 0) begin
        next_word = pending_words.pop_front();
        in_valid    <= 1'b1;
        in_cmd      <= next_word.cmd;
        in_page_key <= next_word.key;
        in_gap = $urandom_range(0, max_wait);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: stall each result word for a drawn number of cycles.
  always @(negedge clk) begin
    if (out_took) out_hold = $urandom_range(0, max_wait);
    if (out_valid && out_hold > 0) begin
      out_hold--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      in_took  <= in_valid && !in_stall;
      out_took <= out_valid && !out_stall;
      if (in_valid && !in_stall)
        expected_replies.push_back(apply_command(lpsc_cmd_t'(in_cmd), in_page_key));
      if (out_valid && !out_stall) begin
        n_results++;
        if (expected_replies.size() == 0) begin
          report_mismatch("result word with nothing expected", 1, 0);
        end else begin
          want_reply = expected_replies.pop_front();
          n_hits      += want_reply.was_resident;
          n_loads     += want_reply.load_issue;
          n_evictions += want_reply.evicted;
          if (out_was_resident !== want_reply.was_resident)
            report_mismatch("was_resident", out_was_resident, want_reply.was_resident);
          if (out_load_issue !== want_reply.load_issue)
            report_mismatch("load_issue", out_load_issue, want_reply.load_issue);
          if (out_slot_x !== want_reply.slot_x)
            report_mismatch("slot_x", out_slot_x, want_reply.slot_x);
          if (out_slot_y !== want_reply.slot_y)
            report_mismatch("slot_y", out_slot_y, want_reply.slot_y);
          if (out_evicted !== want_reply.evicted)
            report_mismatch("evicted", out_evicted, want_reply.evicted);
          if (out_evicted_key !== want_reply.evicted_key)
            report_mismatch("evicted_key", out_evicted_key, want_reply.evicted_key);
        end
      end
    end
  end

  // Sampled at the rising edge, where the queues and in_valid are settled.
  task automatic wait_idle();
    do @(posedge clk);
    while (pending_words.size() > 0 || in_valid || expected_replies.size() > 0);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_side(logic [3:0] raw);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= raw;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    geom_side = (raw == 4'd0) ? 1 : (raw > 4'd8) ? 8 : int'(raw);
    while (geom_side > 1 && geom_side * geom_side > SLOTS) geom_side--;
    drop_all();
    n_sides++;
    @(posedge clk);
  endtask

  task automatic random_phase(logic [3:0] raw, int count, int wait_max);
    logic [15:0] pool[$];
    logic [15:0] k;
    int          cap;
    int          pick;
    int          n;
    int          cursor;
    write_side(raw);
    max_wait = wait_max;
    cap = geom_side * geom_side;
    repeat (cap + 2 + $urandom_range(0, cap / 4)) pool.push_back(16'($urandom()));
    n = 0;
    cursor = 0;
    while (n < count) begin
      // walk the pool half the time so loads cycle past capacity
      if ($urandom_range(0, 1)) begin
        k = pool[cursor % pool.size()];
        cursor++;
      end else begin
        k = pool[$urandom_range(0, pool.size() - 1)];
      end
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        send(CMD_REQUEST, k);
        send(CMD_LOAD, k);
        n += 2;
      end else begin
        if (pick < 72) send(CMD_TOUCH, k);
        else if (pick < 84) send(CMD_LOAD, k);
        else if (pick < 92) send(CMD_REQUEST, k);
        else if (pick < 94) send(CMD_CLEAR, k);
        else send(lpsc_cmd_t'($urandom_range(0, 3)), 16'($urandom()));
        n++;
      end
    end
    wait_idle();
  endtask

  initial begin
    drop_all();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset geometry: eight by eight
    send(CMD_TOUCH,   16'h0000);
    send(CMD_REQUEST, 16'hFFFF);
    send(CMD_LOAD,    16'hFFFF);
    send(CMD_LOAD,    16'h0000);
    send(CMD_TOUCH,   16'hFFFF);
    send(CMD_REQUEST, 16'h0000);
    send(CMD_LOAD,    16'hFFFF);
    send(CMD_CLEAR,   16'h0000);
    send(CMD_CLEAR,   16'h1234);
    send(CMD_TOUCH,   16'hFFFF);
    wait_idle();

    // single slot: each new load after the first evicts
    write_side(4'd1);
    send(CMD_LOAD,    16'hAAAA);
    send(CMD_LOAD,    16'h5555);
    send(CMD_REQUEST, 16'hAAAA);
    send(CMD_TOUCH,   16'h5555);
    wait_idle();

    // two by two: fill in row order, then evict the oldest after a touch
    write_side(4'd2);
    send(CMD_LOAD,    16'h0001);
    send(CMD_LOAD,    16'h0002);
    send(CMD_LOAD,    16'h0003);
    send(CMD_LOAD,    16'h0004);
    send(CMD_TOUCH,   16'h0001);
    send(CMD_LOAD,    16'h0005);
    send(CMD_LOAD,    16'h0003);
    send(CMD_REQUEST, 16'h0002);
    wait_idle();

    random_phase(4'd15, 160, 15);
    random_phase(4'd0, 35, 15);
    random_phase(4'd3, 35, 3);
    random_phase(4'd8, 140, 0);
    random_phase(4'($urandom_range(4, 7)), 40, 15);
    random_phase(4'($urandom_range(9, 14)), 60, 15);

    $display("checked %0d result words across %0d atlas sizes", n_results, n_sides);
    $display("  %0d resident hits, %0d load requests, %0d evictions",
             n_hits, n_loads, n_evictions);
    if (mismatches == 0 && expected_replies.size() == 0) begin
      $display("lru_page_slot_cache_unit: match");
    end else begin
      $display("lru_page_slot_cache_unit: mismatch");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout waiting for the cache to drain");
    $display("lru_page_slot_cache_unit: mismatch");
    $finish;
  end

endmodule

>>> files.f
rtl/core/lpsc_pkg.sv
rtl/core/lpsc_cell.sv
rtl/core/lpsc_gather.sv
rtl/core/lru_page_slot_cache_unit.sv
sim/testbench.sv
